### sv/bf3_pkg.sv
// types, constants and arithmetic helpers shared by the 3x3 box filter
`default_nettype none

package bf3_pkg;

	localparam int MAX_SIDE    = 16;
	localparam int PIX_W       = 8;
	localparam int POS_W       = $clog2(MAX_SIDE);
	localparam int CFG_W       = 5;
	localparam int SIDE_RESET  = 8;
	localparam int SUM_W       = PIX_W + 4;
	localparam int DIV_SH      = SUM_W + 4;
	localparam int PROD_W      = SUM_W + DIV_SH;
	localparam int RECIP6      = (2 ** DIV_SH) / 6 + 1;
	localparam int RECIP9      = (2 ** DIV_SH) / 9 + 1;
	localparam int MAX_RES     = 4;
	localparam int NRES_W      = $clog2(MAX_RES + 1);
	localparam int FIFO_DEPTH  = 8;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
	localparam int NEED_W      = $clog2(FIFO_DEPTH + 3 * MAX_RES + 1);

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CFG_W-1:0] cfg_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [NRES_W-1:0] nres_t;

	typedef enum logic [1:0] {
		DIV4,
		DIV6,
		DIV9
	} div_t;

	typedef struct packed {
		pix_t pixel;
		pos_t row;
		pos_t column;
		logic last;
	} res_t;

	localparam pos_t SIDE_RESET_M1 = POS_W'(SIDE_RESET - 1);

	// clamp the side register to the legal range and return side - 1
	function automatic pos_t side_m1_of(cfg_t v);
		pos_t r;
		if (v < CFG_W'(2)) begin
			r = POS_W'(1);
		end else if (v > CFG_W'(MAX_SIDE)) begin
			r = POS_W'(MAX_SIDE - 1);
		end else begin
			r = POS_W'(v - CFG_W'(1));
		end
		return r;
	endfunction

	function automatic div_t div_sel(logic rows3, logic cols3);
		div_t d;
		if (rows3 && cols3) begin
			d = DIV9;
		end else if (rows3 || cols3) begin
			d = DIV6;
		end else begin
			d = DIV4;
		end
		return d;
	endfunction

	// truncating mean: shift by two for four taps, reciprocal multiply for six or nine
	function automatic pix_t mean_of(sum_t s, div_t d);
		logic [PROD_W-1:0] p;
		pix_t q;
		p = '0;
		case (d)
			DIV4: begin
				q = PIX_W'(s >> 2);
			end
			DIV6: begin
				p = PROD_W'(s) * PROD_W'(RECIP6);
				q = PIX_W'(p >> DIV_SH);
			end
			DIV9: begin
				p = PROD_W'(s) * PROD_W'(RECIP9);
				q = PIX_W'(p >> DIV_SH);
			end
			default: begin
				q = PIX_W'(s >> 2);
			end
		endcase
		return q;
	endfunction

endpackage

`default_nettype wire

### sv/bf3_if.sv
// stream interfaces of the 3x3 box filter: pixel input, result output, config write
`default_nettype none

interface bf3_pix_in_if;
	logic          valid;
	logic          ready;
	bf3_pkg::pix_t pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface bf3_pix_out_if;
	logic          valid;
	logic          ready;
	bf3_pkg::pix_t pixel_out;
	bf3_pkg::pos_t out_row;
	bf3_pkg::pos_t out_column;
	logic          frame_last;

	modport source (output valid, output pixel_out, output out_row, output out_column,
		output frame_last, input ready);
	modport sink (input valid, input pixel_out, input out_row, input out_column,
		input frame_last, output ready);
endinterface

interface bf3_cfg_if;
	logic          valid;
	logic          ready;
	bf3_pkg::cfg_t image_side;

	modport source (output valid, output image_side, input ready);
	modport sink (input valid, input image_side, output ready);
endinterface

`default_nettype wire

### sv/box_filter_3x3_clipped_border.sv
// top level of the 3x3 box filter with clipped borders
//
//   channel   dir   payload                                          request when
//   pix_in    in    pixel_in                                         valid & ready
//   pix_out   out   pixel_out, out_row, out_column, frame_last       valid & ready
//   cfg       in    image_side                                       valid & ready
//
// one pixel per cycle while pix_in is ready; a result is written to the result queue from the stage 2 registers
// stages: line store read, column sums, divide (shift or reciprocal multiply) into an 8-entry result queue
// pix_in stalls when the queue cannot take four more results beyond those in flight
// the bottom row gives two results for most pixels, so pix_in stalls there while the queue drains
// reset: side 8, position row 0 column 0, queue empty; line stores are never cleared
`default_nettype none

module box_filter_3x3_clipped_border (
	input  logic           clk,
	input  logic           arst_n,
	bf3_pix_in_if.sink     pix_in,
	bf3_pix_out_if.source  pix_out,
	bf3_cfg_if.sink        cfg
);

	localparam int NR = bf3_pkg::MAX_RES;

	bf3_pkg::pos_t side_m1_q;
	bf3_pkg::pos_t row_q;
	bf3_pkg::pos_t col_q;
	logic          in_acc;
	logic          cfg_acc;
	logic          pop;
	logic [NR-1:0] vld_now;

	logic          s1_valid;
	logic [NR-1:0] vld_s1;
	bf3_pkg::pix_t pix_s1;
	bf3_pkg::pos_t row_s1;
	bf3_pkg::pos_t col_s1;
	logic          rge2_s1;
	logic          cge2_s1;
	bf3_pkg::pix_t ra_rd;
	bf3_pkg::pix_t rb_rd;
	bf3_pkg::pix_t win_q [0:2][0:1];
	bf3_pkg::pix_t w [0:2][0:2];
	bf3_pkg::sum_t wm [0:2][0:2];
	bf3_pkg::sum_t s2c [0:2];
	bf3_pkg::sum_t s3c [0:2];
	bf3_pkg::sum_t sums [0:NR-1];

	logic          [NR-1:0] vld_s2;
	bf3_pkg::sum_t sum_s2 [0:NR-1];
	bf3_pkg::pos_t row_s2;
	bf3_pkg::pos_t col_s2;
	logic          rge2_s2;
	logic          cge2_s2;
	bf3_pkg::div_t dv [0:NR-1];
	bf3_pkg::res_t res [0:NR-1];
	bf3_pkg::ptr_t off [0:NR-1];

	bf3_pkg::res_t fifo_q [0:bf3_pkg::FIFO_DEPTH-1];
	bf3_pkg::ptr_t head_q;
	bf3_pkg::ptr_t tail_q;
	bf3_pkg::cnt_t count_q;
	bf3_pkg::cnt_t nw;
	bf3_pkg::nres_t n_s1;
	bf3_pkg::nres_t n_s2;
	logic [bf3_pkg::NEED_W-1:0] need;

	// handshakes
	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid & cfg.ready;
	assign n_s1      = bf3_pkg::NRES_W'($countones(vld_s1));
	assign n_s2      = bf3_pkg::NRES_W'($countones(vld_s2));
	assign need      = bf3_pkg::NEED_W'(count_q) + bf3_pkg::NEED_W'(n_s1)
		+ bf3_pkg::NEED_W'(n_s2) + bf3_pkg::NEED_W'(NR);
	assign pix_in.ready = (need <= bf3_pkg::NEED_W'(bf3_pkg::FIFO_DEPTH));
	assign in_acc    = pix_in.valid & pix_in.ready;
	assign pop       = pix_out.valid & pix_out.ready;

	// results caused by the next pixel, in output order
	always_comb begin
		vld_now[0] = (row_q != '0) && (col_q != '0);
		vld_now[1] = (row_q != '0) && (col_q == side_m1_q);
		vld_now[2] = (row_q == side_m1_q) && (col_q != '0);
		vld_now[3] = (row_q == side_m1_q) && (col_q == side_m1_q);
	end

	// position and side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_m1_q <= bf3_pkg::SIDE_RESET_M1;
			row_q     <= '0;
			col_q     <= '0;
		end else if (cfg_acc) begin
			side_m1_q <= bf3_pkg::side_m1_of(cfg.image_side);
			row_q     <= '0;
			col_q     <= '0;
		end else if (in_acc) begin
			if (col_q == side_m1_q) begin
				col_q <= '0;
				row_q <= (row_q == side_m1_q) ? '0 : row_q + bf3_pkg::POS_W'(1);
			end else begin
				col_q <= col_q + bf3_pkg::POS_W'(1);
			end
		end
	end

	// line stores: ram_a holds row r-2, ram_b holds row r-1
	bf3_ram #(
		.WIDTH(bf3_pkg::PIX_W),
		.DEPTH(bf3_pkg::MAX_SIDE)
	) u_ram_a (
		.clk     (clk),
		.we      (s1_valid),
		.wr_addr (col_s1),
		.wr_data (rb_rd),
		.rd_addr (col_q),
		.rd_data (ra_rd)
	);

	bf3_ram #(
		.WIDTH(bf3_pkg::PIX_W),
		.DEPTH(bf3_pkg::MAX_SIDE)
	) u_ram_b (
		.clk     (clk),
		.we      (s1_valid),
		.wr_addr (col_s1),
		.wr_data (pix_s1),
		.rd_addr (col_q),
		.rd_data (rb_rd)
	);

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			vld_s1   <= '0;
		end else begin
			s1_valid <= in_acc;
			vld_s1   <= in_acc ? vld_now : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pix_in.pixel_in;
			row_s1  <= row_q;
			col_s1  <= col_q;
			rge2_s1 <= (row_q >= bf3_pkg::POS_W'(2));
			cge2_s1 <= (col_q >= bf3_pkg::POS_W'(2));
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w[i][0] = win_q[i][0];
			w[i][1] = win_q[i][1];
		end
		w[0][2] = ra_rd;
		w[1][2] = rb_rd;
		w[2][2] = pix_s1;
		// out-of-image taps drop out of the sums
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				wm[i][j] = bf3_pkg::SUM_W'(w[i][j]
					& {bf3_pkg::PIX_W{(i != 0 || rge2_s1) && (j != 0 || cge2_s1)}});
			end
		end
		for (int j = 0; j < 3; j++) begin
			s2c[j] = wm[1][j] + wm[2][j];
			s3c[j] = s2c[j] + wm[0][j];
		end
		sums[0] = s3c[0] + s3c[1] + s3c[2];
		sums[1] = s3c[1] + s3c[2];
		sums[2] = s2c[0] + s2c[1] + s2c[2];
		sums[3] = s2c[1] + s2c[2];
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= w[i][1];
				win_q[i][1] <= w[i][2];
			end
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= '0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			for (int i = 0; i < NR; i++) begin
				sum_s2[i] <= sums[i];
			end
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			rge2_s2 <= rge2_s1;
			cge2_s2 <= cge2_s1;
		end
	end

	always_comb begin
		dv[0] = bf3_pkg::div_sel(rge2_s2, cge2_s2);
		dv[1] = bf3_pkg::div_sel(rge2_s2, 1'b0);
		dv[2] = bf3_pkg::div_sel(1'b0, cge2_s2);
		dv[3] = bf3_pkg::DIV4;
		for (int i = 0; i < NR; i++) begin
			res[i].pixel = bf3_pkg::mean_of(sum_s2[i], dv[i]);
			res[i].last  = 1'b0;
		end
		res[0].row    = row_s2 - bf3_pkg::POS_W'(1);
		res[0].column = col_s2 - bf3_pkg::POS_W'(1);
		res[1].row    = row_s2 - bf3_pkg::POS_W'(1);
		res[1].column = col_s2;
		res[2].row    = row_s2;
		res[2].column = col_s2 - bf3_pkg::POS_W'(1);
		res[3].row    = row_s2;
		res[3].column = col_s2;
		res[3].last   = 1'b1;
		// pack valid results into consecutive queue slots
		off[0] = tail_q;
		for (int i = 1; i < NR; i++) begin
			off[i] = off[i-1] + bf3_pkg::PTR_W'(vld_s2[i-1]);
		end
	end

	assign nw = bf3_pkg::CNT_W'(n_s2);

	// result queue
	always_ff @(posedge clk) begin
		for (int i = 0; i < NR; i++) begin
			if (vld_s2[i]) begin
				fifo_q[off[i]] <= res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + bf3_pkg::PTR_W'(1);
			end
			tail_q  <= tail_q + bf3_pkg::PTR_W'(nw);
			count_q <= count_q + nw - bf3_pkg::CNT_W'(pop);
		end
	end

	assign pix_out.valid      = (count_q != '0);
	assign pix_out.pixel_out  = fifo_q[head_q].pixel;
	assign pix_out.out_row    = fifo_q[head_q].row;
	assign pix_out.out_column = fifo_q[head_q].column;
	assign pix_out.frame_last = fifo_q[head_q].last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bf3_pkg::CNT_W'(bf3_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_room_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 != '0) |-> (int'(count_q) + int'(nw) <= bf3_pkg::FIFO_DEPTH))
		else $error("results written without queue room");

	a_pos_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= side_m1_q) && (col_q <= side_m1_q))
		else $error("position outside image");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.frame_last) |-> (pix_out.out_row == pix_out.out_column))
		else $error("frame_last off the corner");

endmodule

`default_nettype wire

### sv/bf3_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module bf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire
